@@ src/cbd_pkg.sv @@
// shared constants and types for the circular buffer deque
`timescale 1ns / 1ps
package cbd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ADDR_W     = 2;

  localparam logic [31:0] SENTINEL = 32'h7FFF_FFFF;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PUSH_FRONT = 2'd0;
  localparam mode_t MODE_PUSH_REAR  = 2'd1;
  localparam mode_t MODE_POP_FRONT  = 2'd2;
  localparam mode_t MODE_POP_REAR   = 2'd3;

  localparam logic [ADDR_W-1:0] REG_CAPACITY = '0;

endpackage

@@ src/circular_buffer_deque_core.sv @@
// double-ended queue over a circular slot memory with a configurable capacity
// result: the item is written at accept, both ends are then read through the registered slot memory read,
//   and the result is presented in the out state until it is taken
// flow: one item at a time; a new item is taken only after the result has been taken
// reset: head index and count cleared, capacity 16; slot contents undefined until written
// writing the capacity register empties the queue
`timescale 1ns / 1ps
module circular_buffer_deque_core (
  input  logic                        clk,
  input  logic                        rst,
  // input item channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cbd_pkg::mode_t              mode,
  input  logic signed [31:0]          value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        ok,
  output logic signed [31:0]          front_value,
  output logic signed [31:0]          rear_value,
  output logic [cbd_pkg::CNT_W-1:0]   count,
  output logic                        full_res,
  output logic                        empty_res,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cbd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [IDX_W-1:0]      head;
  logic [IDX_W-1:0]      head_next;
  logic [CNT_W-1:0]      held;
  logic [CNT_W-1:0]      held_next;
  logic [CNT_W-1:0]      capacity;
  logic [DATA_WIDTH-1:0] slots [DEPTH];
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_rear;

  logic                  accept;
  logic                  cfg_write;
  logic                  is_full;
  logic                  queue_empty;
  logic                  op_ok;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [CNT_W:0]        rear_sum;
  logic [CNT_W:0]        push_sum;
  logic [CNT_W:0]        pop_sum;
  logic [IDX_W-1:0]      rear_idx;
  logic [IDX_W-1:0]      push_rear_idx;
  logic [IDX_W-1:0]      head_inc;
  logic [IDX_W-1:0]      head_dec;
  logic [CNT_W-1:0]      cap_clamped;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = 32'(capacity);

  // capacity clamp to 1..DEPTH
  always_comb begin
    if (pwdata[CNT_W-1:0] == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (pwdata[CNT_W-1:0] > CNT_W'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = pwdata[CNT_W-1:0];
    end
  end

  assign is_full     = (held >= capacity);
  assign queue_empty = (held == '0);

  // wrapped indexes: every sum stays below twice the capacity
  assign push_sum      = {1'b0, CNT_W'(head)} + {1'b0, held};
  assign push_rear_idx = (push_sum >= {1'b0, capacity}) ?
                         IDX_W'(push_sum - {1'b0, capacity}) : IDX_W'(push_sum);
  assign pop_sum       = {1'b0, CNT_W'(head)} + (CNT_W + 1)'(1);
  assign head_inc      = (pop_sum >= {1'b0, capacity}) ?
                         IDX_W'(pop_sum - {1'b0, capacity}) : IDX_W'(pop_sum);
  assign head_dec      = (head == '0) ? IDX_W'(capacity - CNT_W'(1)) : head - IDX_W'(1);
  assign rear_sum      = push_sum - (CNT_W + 1)'(1);
  assign rear_idx      = (rear_sum >= {1'b0, capacity}) ?
                         IDX_W'(rear_sum - {1'b0, capacity}) : IDX_W'(rear_sum);

  // operation decode
  always_comb begin
    head_next = head;
    held_next = held;
    op_ok     = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = head_dec;
    unique case (mode)
      MODE_PUSH_FRONT: begin
        if (!is_full) begin
          head_next = head_dec;
          held_next = held + CNT_W'(1);
          wr_en     = 1'b1;
          wr_idx    = head_dec;
          op_ok     = 1'b1;
        end
      end
      MODE_PUSH_REAR: begin
        if (!is_full) begin
          held_next = held + CNT_W'(1);
          wr_en     = 1'b1;
          wr_idx    = push_rear_idx;
          op_ok     = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (!queue_empty) begin
          head_next = head_inc;
          held_next = held - CNT_W'(1);
          op_ok     = 1'b1;
        end
      end
      MODE_POP_REAR: begin
        if (!queue_empty) begin
          held_next = held - CNT_W'(1);
          op_ok     = 1'b1;
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // sequencer: accept and write, read both ends, present the result
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      held     <= '0;
      capacity <= CNT_W'(DEPTH);
    end else begin
      state <= state_next;
      if (cfg_write) begin
        capacity <= cap_clamped;
        head     <= '0;
        held     <= '0;
      end else if (accept) begin
        head <= head_next;
        held <= held_next;
      end
    end
  end

  // result flags captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      ok        <= op_ok;
      count     <= held_next;
      full_res  <= (held_next == capacity);
      empty_res <= (held_next == '0);
    end
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      slots[wr_idx] <= value[DATA_WIDTH-1:0];
    end
    if (state == ST_READ) begin
      rd_front <= slots[head];
      rd_rear  <= slots[rear_idx];
    end
  end

  // empty queue reads the sentinel at both ends
  assign front_value = empty_res ? SENTINEL : 32'(rd_front);
  assign rear_value  = empty_res ? SENTINEL : 32'(rd_rear);

  // checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= capacity)
    else $error("held count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    capacity == '0 || CNT_W'(head) < capacity)
    else $error("head index outside capacity");

  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    accept |=> !out_valid ##1 out_valid)
    else $error("result not presented two cycles after accept");

  a_count_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (empty_res == (count == '0)))
    else $error("empty flag disagrees with count");

  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    capacity >= CNT_W'(1) && capacity <= CNT_W'(DEPTH))
    else $error("capacity out of range");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the circular buffer deque core
`timescale 1ns / 1ps
module tb_top;
  import cbd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic             ok;
    logic [31:0]      front;
    logic [31:0]      rear;
    logic [CNT_W-1:0] cnt;
    logic             full;
    logic             empty;
  } deque_res_t;

  typedef enum logic [1:0] {ROW_OP, ROW_OP_CHK, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    mode_t       m;
    logic [31:0] v;
    deque_res_t  res;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  mode_t               mode;
  logic signed [31:0]  value;
  logic                out_valid;
  logic                out_stall;
  logic                ok;
  logic signed [31:0]  front_value;
  logic signed [31:0]  rear_value;
  logic [CNT_W-1:0]    count;
  logic                full_res;
  logic                empty_res;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // shadow copy of the deque state
  logic [31:0]  shadow_slots [DEPTH];
  int unsigned  shadow_head;
  int unsigned  shadow_held;
  int unsigned  shadow_cap;

  deque_res_t   pending_results [$];
  dir_row_t     dir_rows [$];
  int           fail_count;
  bit           quiet;
  bit           sender_idles;
  bit           hold_req;

  circular_buffer_deque_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .front_value (front_value),
    .rear_value  (rear_value),
    .count       (count),
    .full_res    (full_res),
    .empty_res   (empty_res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // index wrap against the capacity in use
  function automatic int unsigned wrap_slot(int unsigned idx);
    if (idx >= shadow_cap) begin
      idx -= shadow_cap;
    end
    return idx;
  endfunction

  function automatic int unsigned rear_slot();
    return wrap_slot(shadow_head + shadow_held - 1);
  endfunction

  // capacity write: clamp to 1..DEPTH and empty the deque
  function automatic void load_capacity(logic [31:0] raw);
    int unsigned c;
    c = raw[4:0];
    if (c < 1) begin
      c = 1;
    end
    if (c > DEPTH) begin
      c = DEPTH;
    end
    shadow_cap  = c;
    shadow_head = 0;
    shadow_held = 0;
  endfunction

  // apply one deque operation and return the result it reports
  function automatic deque_res_t deque_apply(mode_t m, logic [31:0] v);
    deque_res_t r;
    r    = '0;
    r.ok = 1'b0;
    case (m)
      MODE_PUSH_FRONT: begin
        if (shadow_held < shadow_cap) begin
          shadow_head = (shadow_head == 0) ? shadow_cap - 1 : shadow_head - 1;
          shadow_slots[shadow_head] = v;
          shadow_held++;
          r.ok = 1'b1;
        end
      end
      MODE_PUSH_REAR: begin
        if (shadow_held < shadow_cap) begin
          shadow_held++;
          shadow_slots[rear_slot()] = v;
          r.ok = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_held != 0) begin
          shadow_head = wrap_slot(shadow_head + 1);
          shadow_held--;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (shadow_held != 0) begin
          shadow_held--;
          r.ok = 1'b1;
        end
      end
    endcase
    if (shadow_held == 0) begin
      r.front = SENTINEL;
      r.rear  = SENTINEL;
    end else begin
      r.front = shadow_slots[shadow_head];
      r.rear  = shadow_slots[rear_slot()];
    end
    r.cnt   = shadow_held[CNT_W-1:0];
    r.full  = (shadow_held == shadow_cap);
    r.empty = (shadow_held == 0);
    return r;
  endfunction

  function automatic void add_row(row_kind_t k, mode_t m, logic [31:0] v, logic e_ok,
                                  logic [31:0] e_front, logic [31:0] e_rear,
                                  int e_cnt, logic e_full, logic e_empty);
    dir_row_t row;
    row.kind      = k;
    row.m         = m;
    row.v         = v;
    row.res.ok    = e_ok;
    row.res.front = e_front;
    row.res.rear  = e_rear;
    row.res.cnt   = e_cnt[CNT_W-1:0];
    row.res.full  = e_full;
    row.res.empty = e_empty;
    dir_rows.push_back(row);
  endfunction

  // offer one item, wait for it to be taken, then maybe idle; returns at a falling edge
  task automatic send_item(mode_t m, logic [31:0] v, bit typed, deque_res_t typed_res);
    deque_res_t predicted;
    in_valid = 1'b1;
    mode     = m;
    value    = v;
    do @(posedge clk); while (in_stall);
    predicted = deque_apply(m, v);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
    if (sender_idles && !quiet && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // wait for all pending results, then write the capacity register over the bus
  task automatic write_capacity(logic [31:0] raw);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = REG_CAPACITY;
    pwdata  = raw;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    load_capacity(raw);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // result receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(0, 24)) @(negedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    deque_res_t got;
    deque_res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{ok, front_value, rear_value, count, full_res, empty_res};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result item: ok=%0d front=%h rear=%h count=%0d",
                   got.ok, got.front, got.rear, got.cnt);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: exp ok=%0d front=%h rear=%h count=%0d full=%0d empty=%0d",
                     want.ok, want.front, want.rear, want.cnt, want.full, want.empty);
            $display("          got ok=%0d front=%h rear=%h count=%0d full=%0d empty=%0d",
                     got.ok, got.front, got.rear, got.cnt, got.full, got.empty);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("FAIL circular_buffer_deque_core");
    $finish;
  end

  // stimulus
  initial begin
    logic [31:0] v;
    mode_t       m;
    bit          push_bias;
    int          run_left;
    int unsigned raw_cap;

    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_PUSH_FRONT;
    value        = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = REG_CAPACITY;
    pwdata       = '0;
    fail_count   = 0;
    quiet        = 1'b0;
    sender_idles = 1'b1;
    hold_req     = 1'b0;
    run_left     = 0;
    push_bias    = 1'b1;
    shadow_cap   = DEPTH;
    shadow_head  = 0;
    shadow_held  = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: empty pops, extreme values, capacity one, clamping, wrap at capacity three
    add_row(ROW_OP_CHK, MODE_POP_FRONT,  32'h1234_5678, 0, SENTINEL, SENTINEL, 0, 0, 1);
    add_row(ROW_OP_CHK, MODE_POP_REAR,   32'hFFFF_FFFF, 0, SENTINEL, SENTINEL, 0, 0, 1);
    add_row(ROW_OP_CHK, MODE_PUSH_FRONT, 32'h8000_0000, 1, 32'h8000_0000, 32'h8000_0000, 1, 0, 0);
    add_row(ROW_OP_CHK, MODE_PUSH_REAR,  32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF, 2, 0, 0);
    add_row(ROW_OP_CHK, MODE_PUSH_FRONT, 32'h0000_0000, 1, 32'h0000_0000, 32'h7FFF_FFFF, 3, 0, 0);
    add_row(ROW_OP_CHK, MODE_PUSH_REAR,  32'hFFFF_FFFF, 1, 32'h0000_0000, 32'hFFFF_FFFF, 4, 0, 0);
    add_row(ROW_OP_CHK, MODE_POP_REAR,   32'h0000_0000, 1, 32'h0000_0000, 32'h7FFF_FFFF, 3, 0, 0);
    add_row(ROW_OP_CHK, MODE_POP_FRONT,  32'h0000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF, 2, 0, 0);
    add_row(ROW_OP_CHK, MODE_POP_FRONT,  32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0);
    add_row(ROW_OP_CHK, MODE_POP_REAR,   32'h0000_0000, 1, SENTINEL, SENTINEL, 0, 0, 1);
    add_row(ROW_CAP,    MODE_PUSH_FRONT, 32'd0,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP_CHK, MODE_PUSH_REAR,  32'd5,         1, 32'd5, 32'd5, 1, 1, 0);
    add_row(ROW_OP_CHK, MODE_PUSH_FRONT, 32'd6,         0, 32'd5, 32'd5, 1, 1, 0);
    add_row(ROW_OP_CHK, MODE_PUSH_REAR,  32'd7,         0, 32'd5, 32'd5, 1, 1, 0);
    add_row(ROW_OP_CHK, MODE_POP_FRONT,  32'd0,         1, SENTINEL, SENTINEL, 0, 0, 1);
    add_row(ROW_OP_CHK, MODE_PUSH_FRONT, 32'h5555_5555, 1, 32'h5555_5555, 32'h5555_5555, 1, 1, 0);
    add_row(ROW_CAP,    MODE_PUSH_FRONT, 32'd3,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_PUSH_FRONT, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_PUSH_FRONT, 32'd1,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_PUSH_REAR,  32'd2,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_PUSH_REAR,  32'd3,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_POP_FRONT,  32'd0,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_PUSH_REAR,  32'd4,         0, 0, 0, 0, 0, 0);
    add_row(ROW_OP,     MODE_POP_REAR,   32'd0,         0, 0, 0, 0, 0, 0);
    add_row(ROW_CAP,    MODE_PUSH_FRONT, 32'd31,        0, 0, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        write_capacity(dir_rows[i].v);
      end else begin
        send_item(dir_rows[i].m, dir_rows[i].v, dir_rows[i].kind == ROW_OP_CHK,
                  dir_rows[i].res);
      end
    end

    // random phases, each under its own capacity
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: raw_cap = DEPTH;
        1: raw_cap = 1;
        2: raw_cap = 31;
        3: raw_cap = 0;
        4: raw_cap = 2;
        5: raw_cap = 20;
        default: raw_cap = $urandom_range(0, 31);
      endcase
      write_capacity(raw_cap);
      quiet        = (ph == PHASES - 1);
      sender_idles = (ph % 3 != 1);
      // long receiver hold-off while the sender keeps offering items
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // runs that lean toward pushes or pops to reach full and empty
        if (run_left == 0) begin
          push_bias = $urandom_range(0, 1);
          run_left  = $urandom_range(4, 40);
        end
        run_left--;
        if ($urandom_range(0, 3) != 0) begin
          if (push_bias) begin
            m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
          end else begin
            m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
          end
        end else begin
          case ($urandom_range(0, 3))
            0: m = MODE_PUSH_FRONT;
            1: m = MODE_PUSH_REAR;
            2: m = MODE_POP_FRONT;
            default: m = MODE_POP_REAR;
          endcase
        end
        case ($urandom_range(0, 7))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          3: v = 32'h7FFF_FFFF;
          default: v = $urandom;
        endcase
        send_item(m, v, 1'b0, '0);
      end
    end

    // drain and settle
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS circular_buffer_deque_core");
    end else begin
      $display("FAIL circular_buffer_deque_core");
    end
    $finish;
  end

endmodule
